FILE: rtl/i2c_master_byte_engine_assert.svh
// ----------------------------------------------------------------------------
// I2C master byte engine assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

`ifndef SYNTH
// Assertion disabled while the active-low reset is asserted
`define I2CM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Assertion that is checked during reset as well
`define I2CM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define I2CM_ASSERT(lbl, clk, rst_n, prop, msg)
`define I2CM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

    // Queue between front and back
    localparam int QueuePtrW  = 2;
    localparam int QueueDepth = 1 << QueuePtrW;
    localparam int QueueCntW  = QueuePtrW + 1;

    localparam logic [15:0] WaitReset = 16'd100;

    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_STOP    = 3'd1,
        OP_SEND    = 3'd2,
        OP_RX_ACK  = 3'd3,
        OP_RX_NACK = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BUS_BUSY = 3'd1,
        ST_BUS_ERR  = 3'd2,
        ST_NO_ACK   = 3'd3,
        ST_REJECT   = 3'd4
    } t_status;

    // Classified word kind
    typedef enum logic [1:0] {
        K_TICK = 2'd0,
        K_CMD  = 2'd1,
        K_BAD  = 2'd2
    } t_kind;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_ST_HI   = 5'd1,
        PH_ST_LO   = 5'd2,
        PH_ST_HOLD = 5'd3,
        PH_SP_A    = 5'd4,
        PH_SP_B    = 5'd5,
        PH_SP_C    = 5'd6,
        PH_TX_DATA = 5'd7,
        PH_TX_HIGH = 5'd8,
        PH_TX_LOW  = 5'd9,
        PH_AK_REL  = 5'd10,
        PH_AK_HIGH = 5'd11,
        PH_AK_END  = 5'd12,
        PH_RX_HIGH = 5'd13,
        PH_RX_LOW  = 5'd14,
        PH_MA_DATA = 5'd15,
        PH_MA_HIGH = 5'd16,
        PH_MA_LOW  = 5'd17
    } t_phase;

    // One classified word as it travels through the queue
    typedef struct packed {
        t_kind      kind;
        t_op        op;
        logic [7:0] tx_byte;
        logic       sda;
    } t_item;

endpackage

`default_nettype wire

FILE: rtl/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Input side: accepts words and classifies them as tick, command or bad op.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_front
    import i2cm_pkg::*;
(
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_req_type,
    input  wire logic [2:0] i_op,
    input  wire logic [7:0] i_tx_byte,
    input  wire logic       i_sda_level,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_item           o_item
);

    // Accept whenever the queue has room
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Classify the word
    always_comb begin
        o_item         = '0;
        o_item.op      = t_op'(i_op);
        o_item.tx_byte = i_tx_byte;
        o_item.sda     = i_sda_level;
        if (!i_req_type) begin
            o_item.kind = K_TICK;
        end else if (i_op <= 3'(OP_RX_NACK)) begin
            o_item.kind = K_CMD;
        end else begin
            o_item.kind = K_BAD;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/i2cm_queue.sv
// ----------------------------------------------------------------------------
// i2cm_queue
// Small show-ahead queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_queue
    import i2cm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_item      o_item
);

    t_item                 r_mem [QueueDepth];
    logic [QueuePtrW-1:0]  r_wr_ptr;
    logic [QueuePtrW-1:0]  r_rd_ptr;
    logic [QueueCntW-1:0]  r_count;

    assign o_full  = (r_count == QueueCntW'(QueueDepth));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Store pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QueuePtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QueuePtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QueueCntW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QueueCntW'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// Back side: pin sequencer with phase wait counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_byte_engine_assert.svh"

module i2cm_seq
    import i2cm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_q_empty,
    input  wire t_item       i_item,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_scl_release,
    output logic             o_sda_release,
    output logic             o_busy_res,
    output logic             o_done_res,
    output logic [2:0]       o_status,
    output logic [7:0]       o_rx_byte
);

    logic [15:0] r_wait_cfg;
    t_phase      r_phase,      n_phase;
    logic [15:0] r_wait_count, n_wait_count;
    logic [3:0]  r_bit_count,  n_bit_count;
    logic [7:0]  r_shift,      n_shift;
    t_op         r_cur_op,     n_cur_op;
    logic        r_scl,        n_scl;
    logic        r_sda,        n_sda;
    t_status     r_last,       n_last;
    logic [7:0]  r_rx,         n_rx;

    logic        r_out_valid;
    logic        r_out_scl, r_out_sda, r_out_busy, r_out_done;
    t_status     r_out_status;
    logic [7:0]  r_out_rx;

    logic        step;
    logic        is_idle;
    logic        cmd_ok;
    logic        rejected;
    logic        fire;
    logic        done;
    logic [15:0] wait_load;
    logic [3:0]  bit_inc;

    // Take the next word when the result register is free or draining
    assign step     = !i_q_empty && (!r_out_valid || i_out_ready);
    assign o_pop    = step;
    assign is_idle  = (r_phase == PH_IDLE);
    assign cmd_ok   = step && (i_item.kind == K_CMD) && is_idle;
    assign rejected = (i_item.kind == K_BAD) || ((i_item.kind == K_CMD) && !is_idle);
    // A tick that ends the current wait
    assign fire     = step && (i_item.kind == K_TICK) && !is_idle && (r_wait_count <= 16'd1);
    assign wait_load = (r_wait_cfg == '0) ? 16'd1 : r_wait_cfg;
    assign bit_inc  = r_bit_count + 4'd1;
    assign done     = fire && (n_phase == PH_IDLE);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (cmd_ok) begin
            unique case (i_item.op)
                OP_START: n_phase = PH_ST_HI;
                OP_STOP:  n_phase = PH_SP_A;
                OP_SEND:  n_phase = PH_TX_DATA;
                default:  n_phase = PH_RX_HIGH;
            endcase
        end else if (fire) begin
            unique case (r_phase)
                PH_ST_HI:   n_phase = i_item.sda ? PH_ST_LO : PH_IDLE;
                PH_ST_LO:   n_phase = i_item.sda ? PH_IDLE : PH_ST_HOLD;
                PH_SP_A:    n_phase = PH_SP_B;
                PH_SP_B:    n_phase = PH_SP_C;
                PH_TX_DATA: n_phase = PH_TX_HIGH;
                PH_TX_HIGH: n_phase = PH_TX_LOW;
                PH_TX_LOW:  n_phase = bit_inc[3] ? PH_AK_REL : PH_TX_DATA;
                PH_AK_REL:  n_phase = PH_AK_HIGH;
                PH_AK_HIGH: n_phase = i_item.sda ? PH_IDLE : PH_AK_END;
                PH_RX_HIGH: n_phase = PH_RX_LOW;
                PH_RX_LOW:  n_phase = bit_inc[3] ? PH_MA_DATA : PH_RX_HIGH;
                PH_MA_DATA: n_phase = PH_MA_HIGH;
                PH_MA_HIGH: n_phase = PH_MA_LOW;
                default:    n_phase = PH_IDLE;
            endcase
        end
    end

    // Wait counter: load on every pin phase, count down on ticks
    always_comb begin
        n_wait_count = r_wait_count;
        if (cmd_ok) begin
            n_wait_count = wait_load;
        end else if (fire) begin
            n_wait_count = (n_phase == PH_IDLE) ? 16'd0 : wait_load;
        end else if (step && (i_item.kind == K_TICK) && !is_idle) begin
            n_wait_count = r_wait_count - 16'd1;
        end
    end

    // Pin drives, shifter, bit counter and status
    always_comb begin
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_cur_op    = r_cur_op;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_last      = r_last;
        n_rx        = r_rx;
        if (cmd_ok) begin
            n_cur_op    = i_item.op;
            n_bit_count = '0;
            unique case (i_item.op)
                OP_START: begin
                    n_sda = 1'b1;
                    n_scl = 1'b1;
                end
                OP_STOP: begin
                    n_sda = 1'b0;
                end
                OP_SEND: begin
                    n_sda   = i_item.tx_byte[7];
                    n_shift = {i_item.tx_byte[6:0], 1'b0};
                end
                default: begin
                    n_shift = '0;
                    n_sda   = 1'b1;
                    n_scl   = 1'b1;
                end
            endcase
        end else if (fire) begin
            unique case (r_phase)
                PH_ST_HI: begin
                    if (i_item.sda) begin
                        n_sda = 1'b0;
                    end else begin
                        n_last = ST_BUS_BUSY;
                    end
                end
                PH_ST_LO: begin
                    if (i_item.sda) begin
                        n_last = ST_BUS_ERR;
                    end else begin
                        n_scl = 1'b0;
                    end
                end
                PH_SP_A:    n_scl = 1'b1;
                PH_SP_B:    n_sda = 1'b1;
                PH_TX_DATA: n_scl = 1'b1;
                PH_TX_HIGH: n_scl = 1'b0;
                PH_TX_LOW: begin
                    n_bit_count = bit_inc;
                    if (bit_inc[3]) begin
                        n_sda = 1'b1;
                    end else begin
                        n_sda   = r_shift[7];
                        n_shift = {r_shift[6:0], 1'b0};
                    end
                end
                PH_AK_REL:  n_scl = 1'b1;
                PH_AK_HIGH: begin
                    n_scl = 1'b0;
                    if (i_item.sda) begin
                        n_last = ST_NO_ACK;
                    end
                end
                PH_RX_HIGH: begin
                    n_shift = {r_shift[6:0], i_item.sda};
                    n_scl   = 1'b0;
                end
                PH_RX_LOW: begin
                    n_bit_count = bit_inc;
                    if (bit_inc[3]) begin
                        n_rx  = r_shift;
                        n_sda = (r_cur_op == OP_RX_ACK) ? 1'b0 : 1'b1;
                    end else begin
                        n_scl = 1'b1;
                    end
                end
                PH_MA_DATA: n_scl = 1'b1;
                PH_MA_HIGH: n_scl = 1'b0;
                PH_ST_HOLD, PH_SP_C, PH_AK_END, PH_MA_LOW: begin
                    n_last = ST_OK;
                end
                default: begin
                end
            endcase
        end
    end

    // Hold the configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_cfg <= WaitReset;
        end else if (i_cfg_we) begin
            r_wait_cfg <= i_cfg_wdata;
        end
    end

    // Advance sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_wait_count <= '0;
            r_bit_count  <= '0;
            r_shift      <= '0;
            r_cur_op     <= OP_START;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_last       <= ST_OK;
            r_rx         <= '0;
        end else if (step) begin
            r_phase      <= n_phase;
            r_wait_count <= n_wait_count;
            r_bit_count  <= n_bit_count;
            r_shift      <= n_shift;
            r_cur_op     <= n_cur_op;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_last       <= n_last;
            r_rx         <= n_rx;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_scl    <= n_scl;
            r_out_sda    <= n_sda;
            r_out_busy   <= (n_phase != PH_IDLE);
            r_out_done   <= done;
            r_out_status <= rejected ? ST_REJECT : n_last;
            r_out_rx     <= n_rx;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_scl_release = r_out_scl;
    assign o_sda_release = r_out_sda;
    assign o_busy_res    = r_out_busy;
    assign o_done_res    = r_out_done;
    assign o_status      = r_out_status;
    assign o_rx_byte     = r_out_rx;

    `I2CM_ASSERT(a_busy_has_wait, i_clk, i_rst_n, (r_phase != PH_IDLE) |-> (r_wait_count != 16'd0), "active phase with zero wait count")
    `I2CM_ASSERT(a_bit_count_range, i_clk, i_rst_n, r_bit_count <= 4'd8, "bit count beyond eight")
    `I2CM_ASSERT(a_done_not_busy, i_clk, i_rst_n, (r_out_valid && r_out_done) |-> !r_out_busy, "done result still shows busy")
    `I2CM_ASSERT(a_reject_status, i_clk, i_rst_n, (step && rejected) |=> (r_out_valid && (r_out_status == ST_REJECT)), "rejected word without reject status")

endmodule

`default_nettype wire

FILE: rtl/i2c_master_byte_engine.sv
// Path: an accepted word is written into the queue; when the sequencer takes it,
// its result is written into the result register.
// Throughput: one word per cycle, ticks and commands alike, while the queue has
// room and the result register drains; a 4-entry queue decouples input and output.
// Reset: synchronous, active low; clears the queue, the sequencer (idle, pins
// released) and the result valid flag; the wait register reloads 100.
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master byte controller: start, stop, byte send and receive with ack.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine
    import i2cm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_req_type,
    input  wire logic [2:0]  i_op,
    input  wire logic [7:0]  i_tx_byte,
    input  wire logic        i_sda_level,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_scl_release,
    output logic             o_sda_release,
    output logic             o_busy_res,
    output logic             o_done_res,
    output logic [2:0]       o_status,
    output logic [7:0]       o_rx_byte
);

    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;
    t_item push_item;
    t_item head_item;

    i2cm_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_op        (i_op),
        .i_tx_byte   (i_tx_byte),
        .i_sda_level (i_sda_level),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_item      (push_item)
    );

    i2cm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (head_item)
    );

    i2cm_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_q_empty     (q_empty),
        .i_item        (head_item),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_scl_release (o_scl_release),
        .o_sda_release (o_sda_release),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_status      (o_status),
        .o_rx_byte     (o_rx_byte)
    );

endmodule

`default_nettype wire
